// File: src/sm3_pkg.sv
`timescale 1ns / 1ps
package sm3_pkg;

    typedef struct packed {
        logic [31:0] message_word;
        logic [2:0]  byte_count;
        logic        last;
    } t_in_req;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } t_state;

    // word sources for the block buffer
    typedef enum logic [1:0] {
        SRC_INPUT,
        SRC_ZERO,
        SRC_LEN_HI,
        SRC_LEN_LO
    } t_src;

    // controller to datapath
    typedef struct packed {
        logic       push;       // write one word into the block
        t_src       src;
        logic       add_len;    // accumulate input length
        logic       pad_last;   // input word is the last one
        logic       extra_pad;  // push 0x80000000
        logic       comp_start; // load round regs from chaining value
        logic       comp_round; // run one round
        logic       comp_fold;  // fold round regs into chaining value
        logic       reset_msg;  // reload iv and clear length
    } t_ctrl;

    localparam logic [31:0] T_LO = 32'h79cc4519;
    localparam logic [31:0] T_HI = 32'h7a879d8a;
    localparam logic [255:0] IV = {32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
                                   32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};
    localparam logic [31:0] PAD_WORD = 32'h80000000;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

endpackage

// File: src/sm3_datapath.sv
`timescale 1ns / 1ps
module sm3_datapath
    import sm3_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctrl       i_ctrl,
    input  t_in_req     i_req,
    input  logic [2:0]  i_dig_sel,
    output logic [3:0]  o_pos,
    output logic        o_block_full,
    output logic [31:0] o_dig_word
);

    logic [31:0]  r_w [16];
    logic [31:0]  r_reg [8];
    logic [255:0] r_cv;
    logic [63:0]  r_bits;
    logic [3:0]   r_pos;
    logic [5:0]   r_rnd;
    logic         r_full;

    logic [2:0]  cnt;
    logic [31:0] mask, pword, wr_data, w_new, t_rot, a12, ss1, ss2, ff, gg, tt1, tt2;
    logic [31:0] x16;

    // clamp count, mask and pad the last word; other words pass whole; then select the word source
    always_comb begin
        cnt = (i_req.byte_count > 3'd4) ? 3'd4 : i_req.byte_count;
        mask = ~(32'hffffffff >> {cnt, 3'b000});
        if (cnt == 3'd4 || !i_ctrl.pad_last) mask = 32'hffffffff;
        pword = i_req.message_word & mask;
        if (i_ctrl.pad_last && cnt != 3'd4)
            pword = pword | ({PAD_BYTE, 24'h0} >> {cnt, 3'b000});
        unique case (i_ctrl.src)
            SRC_INPUT:  wr_data = i_ctrl.extra_pad ? PAD_WORD : pword;
            SRC_ZERO:   wr_data = '0;
            SRC_LEN_HI: wr_data = r_bits[63:32];
            SRC_LEN_LO: wr_data = r_bits[31:0];
            default:    wr_data = '0;
        endcase
    end

    // round logic, window holds w[k..k+15]
    always_comb begin
        x16 = r_w[0] ^ r_w[7] ^ rotl(r_w[13], 5'd15);
        w_new = x16 ^ rotl(x16, 5'd15) ^ rotl(x16, 5'd23) ^ rotl(r_w[3], 5'd7) ^ r_w[10];
        t_rot = rotl((r_rnd < 6'd16) ? T_LO : T_HI, r_rnd[4:0]);
        a12 = rotl(r_reg[0], 5'd12);
        ss1 = rotl(a12 + r_reg[4] + t_rot, 5'd7);
        ss2 = ss1 ^ a12;
        if (r_rnd < 6'd16) begin
            ff = r_reg[0] ^ r_reg[1] ^ r_reg[2];
            gg = r_reg[4] ^ r_reg[5] ^ r_reg[6];
        end else begin
            ff = (r_reg[0] & r_reg[1]) | (r_reg[0] & r_reg[2]) | (r_reg[1] & r_reg[2]);
            gg = (r_reg[4] & r_reg[5]) | (~r_reg[4] & r_reg[6]);
        end
        tt1 = ff + r_reg[3] + ss2 + (r_w[0] ^ r_w[4]);
        tt2 = gg + r_reg[7] + ss1 + r_w[0];
    end

    // control state of datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv   <= IV;
            r_bits <= '0;
            r_pos  <= '0;
            r_full <= 1'b0;
            r_rnd  <= '0;
        end else begin
            r_full <= 1'b0;
            if (i_ctrl.add_len)
                r_bits <= r_bits + (i_ctrl.pad_last ? {58'd0, cnt, 3'b000} : 64'd32);
            if (i_ctrl.push) begin
                r_pos <= r_pos + 4'd1;
                r_full <= (r_pos == 4'd15);
            end
            if (i_ctrl.comp_start) r_rnd <= '0;
            else if (i_ctrl.comp_round) r_rnd <= r_rnd + 6'd1;
            if (i_ctrl.comp_fold)
                r_cv <= r_cv ^ {r_reg[0], r_reg[1], r_reg[2], r_reg[3],
                                r_reg[4], r_reg[5], r_reg[6], r_reg[7]};
            if (i_ctrl.reset_msg) begin
                r_cv   <= IV;
                r_bits <= '0;
                r_pos  <= '0;
            end
        end
    end

    // message window and working registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push)
            r_w[r_pos] <= wr_data;
        if (i_ctrl.comp_start) begin
            for (int i = 0; i < 8; i++)
                r_reg[i] <= r_cv[255 - 32*i -: 32];
        end else if (i_ctrl.comp_round) begin
            for (int i = 0; i < 15; i++)
                r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
            r_reg[3] <= r_reg[2];
            r_reg[2] <= rotl(r_reg[1], 5'd9);
            r_reg[1] <= r_reg[0];
            r_reg[0] <= tt1;
            r_reg[7] <= r_reg[6];
            r_reg[6] <= rotl(r_reg[5], 5'd19);
            r_reg[5] <= r_reg[4];
            r_reg[4] <= tt2 ^ rotl(tt2, 5'd9) ^ rotl(tt2, 5'd17);
        end
    end

    assign o_pos = r_pos;
    assign o_block_full = r_full;
    assign o_dig_word = r_cv[255 - {i_dig_sel, 5'd0} -: 32];

endmodule

// File: src/sm3_ctrl.sv
`timescale 1ns / 1ps
module sm3_ctrl
    import sm3_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_in_req    i_req,
    output logic       o_ready,
    input  logic [3:0] i_pos,
    input  logic       i_block_full,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output logic [2:0] o_dig_sel,
    output t_ctrl      o_ctrl
);

    t_state     r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic       r_fin, n_fin;     // message ended, pad after this block
    logic       r_xpad, n_xpad;   // 0x80 word still owed
    logic       r_hi, n_hi;       // high length word written, low one next
    logic       r_done, n_done;   // length words are in the current block
    logic [2:0] r_sel, n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_fin   <= 1'b0;
            r_xpad  <= 1'b0;
            r_hi    <= 1'b0;
            r_done  <= 1'b0;
            r_sel   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_fin   <= n_fin;
            r_xpad  <= n_xpad;
            r_hi    <= n_hi;
            r_done  <= n_done;
            r_sel   <= n_sel;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_fin = r_fin;
        n_xpad = r_xpad;
        n_hi = r_hi;
        n_done = r_done;
        n_sel = r_sel;
        o_ctrl = '0;
        o_ctrl.src = SRC_INPUT;
        o_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_block_full) begin
                    o_ctrl.comp_start = 1'b1;
                    n_cnt = '0;
                    n_state = ST_COMP;
                end else begin
                    o_ready = 1'b1;
                    if (i_valid) begin
                        o_ctrl.push = 1'b1;
                        o_ctrl.add_len = 1'b1;
                        o_ctrl.pad_last = i_req.last;
                        if (i_req.last) begin
                            n_fin = 1'b1;
                            n_xpad = (i_req.byte_count >= 3'd4);
                            n_state = ST_PAD;
                        end
                    end
                end
            end
            ST_COMP: begin
                o_ctrl.comp_round = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) n_state = ST_FOLD;
            end
            ST_FOLD: begin
                // fold, then emit, keep padding or take more input
                o_ctrl.comp_fold = 1'b1;
                if (r_done) begin
                    n_state = ST_EMIT;
                    n_sel = '0;
                    n_fin = 1'b0;
                    n_done = 1'b0;
                end else if (r_fin) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PAD: begin
                // compress a full block first, then 0x80 word, zeros, length
                if (i_block_full) begin
                    o_ctrl.comp_start = 1'b1;
                    n_cnt = '0;
                    n_state = ST_COMP;
                end else if (r_xpad) begin
                    o_ctrl.push = 1'b1;
                    o_ctrl.extra_pad = 1'b1;
                    n_xpad = 1'b0;
                end else if (i_pos == 4'd14) begin
                    o_ctrl.push = 1'b1;
                    o_ctrl.src = SRC_LEN_HI;
                    n_hi = 1'b1;
                end else if (r_hi) begin
                    o_ctrl.push = 1'b1;
                    o_ctrl.src = SRC_LEN_LO;
                    n_hi = 1'b0;
                    n_done = 1'b1;
                end else begin
                    o_ctrl.push = 1'b1;
                    o_ctrl.src = SRC_ZERO;
                end
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_sel = r_sel + 3'd1;
                    if (r_sel == 3'd7) begin
                        o_ctrl.reset_msg = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_dig_sel = r_sel;

endmodule

// File: src/sm3_hash_engine.sv
`timescale 1ns / 1ps
// channel  | valid       | ready       | payload
// request  | i_in_valid  | o_in_ready  | i_in_req
// result   | o_out_valid | i_out_ready | o_out_req
// a full block is compressed in steps: one load, 64 rounds in the single round unit, one fold
// a non-last word is taken only in the idle state; compressing a full block holds off further words
// the last word adds padding words one a cycle, except while a full block compresses, then eight digest words, one per
// accepted result request
// synchronous active-low reset restores the initial value and clears length
// input is refused while a block compresses, padding runs or the digest is being sent
module sm3_hash_engine
    import sm3_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_req o_out_req
);

    t_ctrl       ctrl;
    logic [3:0]  pos;
    logic        full;
    logic [2:0]  sel;
    logic [31:0] dword;

    sm3_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_valid(i_in_valid), .i_req(i_in_req), .o_ready(o_in_ready),
        .i_pos(pos), .i_block_full(full),
        .i_out_ready, .o_out_valid, .o_dig_sel(sel), .o_ctrl(ctrl)
    );

    sm3_datapath u_dp (
        .i_clk, .i_rst_n, .i_ctrl(ctrl), .i_req(i_in_req), .i_dig_sel(sel),
        .o_pos(pos), .o_block_full(full), .o_dig_word(dword)
    );

    assign o_out_req.digest_word = dword;
    assign o_out_req.word_index  = sel;
    assign o_out_req.last_word   = (sel == 3'd7);

endmodule
